// ===== hdl/erb_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Euler-angle rotation basis block.
package erb_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int FRAC_BITS     = 14;
    localparam int RES_W         = FRAC_BITS + 2;
    localparam int Q             = 30;
    localparam int HORNER_LEVELS = 8;

    localparam int T_W    = Q + 1;
    localparam int T2_W   = Q + 2;
    localparam int ACC_W  = Q + 1;
    localparam int TRIG_W = Q + 2;
    localparam int SUM_W  = Q + 3;

    localparam logic [63:0]      HALF_Q    = 64'd1 << (Q - 1);
    localparam logic [ACC_W-1:0] ONE_Q     = ACC_W'(64'd1 << Q);
    localparam logic [T_W-1:0]   HALF_PI_Q = T_W'(64'd1686629713);
    localparam int               RND_SHIFT = Q - FRAC_BITS;
    localparam int               LIM_Q     = 1 << FRAC_BITS;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] yaw_angle;
        logic signed [ANGLE_BITS-1:0] pitch_angle;
        logic signed [ANGLE_BITS-1:0] roll_angle;
    } t_req;

    typedef struct packed {
        logic signed [RES_W-1:0] right_x;
        logic signed [RES_W-1:0] right_y;
        logic signed [RES_W-1:0] right_z;
        logic signed [RES_W-1:0] up_x;
        logic signed [RES_W-1:0] up_y;
        logic signed [RES_W-1:0] up_z;
        logic signed [RES_W-1:0] fwd_x;
        logic signed [RES_W-1:0] fwd_y;
        logic signed [RES_W-1:0] fwd_z;
    } t_rsp;

    typedef struct packed {
        logic [1:0]     quad;
        logic [T_W-1:0] t;
    } t_side;

    function automatic logic signed [TRIG_W-1:0] mulq(
        input logic signed [TRIG_W-1:0] a,
        input logic signed [TRIG_W-1:0] b
    );
        logic                    neg;
        logic [TRIG_W-1:0]       ua;
        logic [TRIG_W-1:0]       ub;
        logic [2*TRIG_W-1:0]     p;
        logic [TRIG_W-1:0]       m;
        neg = a[TRIG_W-1] ^ b[TRIG_W-1];
        ua  = a[TRIG_W-1] ? $unsigned(-a) : $unsigned(a);
        ub  = b[TRIG_W-1] ? $unsigned(-b) : $unsigned(b);
        p   = (2*TRIG_W)'(ua) * (2*TRIG_W)'(ub) + (2*TRIG_W)'(HALF_Q);
        m   = TRIG_W'(p >> Q);
        return neg ? $signed(-m) : $signed(m);
    endfunction

    function automatic logic [RES_W-1:0] to_out(input logic signed [SUM_W-1:0] v);
        logic             neg;
        logic [SUM_W-1:0] m;
        logic [SUM_W-1:0] r;
        neg = v[SUM_W-1];
        m   = neg ? $unsigned(-v) : $unsigned(v);
        m   = (m + SUM_W'(64'd1 << (RND_SHIFT - 1))) >> RND_SHIFT;
        if (m > SUM_W'(LIM_Q)) begin
            m = SUM_W'(LIM_Q);
        end
        r = neg ? (SUM_W'(0) - m) : m;
        return r[RES_W-1:0];
    endfunction

endpackage

// ===== hdl/euler_to_rotation_basis.sv =====
// Top level: pipelined Z-Y-X Euler angles to right, up and forward basis vectors.
//
// Input channel i_in_valid / o_in_ready carries one request: yaw, pitch and roll as
// binary angles (65536 units per turn). Output channel o_out_valid / i_out_ready
// carries the nine basis components in Q1.14, rounded and saturated to plus or minus one.
// Throughput is one request per cycle while the receiver accepts results. The pipeline
// has 24 register stages: input register, angle scaling, squaring, eight two-stage
// Horner cells per angle, sine and quadrant fold, two product stages, sum stage and
// output register. Each stage advances when it is empty or when the stage after it
// advances, so bubbles close up: while the receiver stalls the block keeps taking
// requests until every stage holds one, and the held result stays unchanged on
// o_out_data. Synchronous reset empties every stage; the first request may be offered
// in the cycle after reset is released. The block keeps no state between requests.
module euler_to_rotation_basis (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  erb_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output erb_pkg::t_rsp o_out_data
);

    localparam int AB      = erb_pkg::ANGLE_BITS;
    localparam int Q       = erb_pkg::Q;
    localparam int T_W     = erb_pkg::T_W;
    localparam int T2_W    = erb_pkg::T2_W;
    localparam int ACC_W   = erb_pkg::ACC_W;
    localparam int TRIG_W  = erb_pkg::TRIG_W;
    localparam int SUM_W   = erb_pkg::SUM_W;
    localparam int LVL     = erb_pkg::HORNER_LEVELS;
    localparam int TP_W    = Q + T_W + 1;
    localparam int T2P_W   = 2 * T_W + 1;
    localparam int SP_W    = T_W + ACC_W + 1;

    localparam int ST_IN   = 0;
    localparam int ST_T    = 1;
    localparam int ST_T2   = 2;
    localparam int ST_CELL = 3;
    localparam int ST_SC   = ST_CELL + 2 * LVL;
    localparam int ST_P1   = ST_SC + 1;
    localparam int ST_P2   = ST_P1 + 1;
    localparam int ST_SUM  = ST_P2 + 1;
    localparam int ST_OUT  = ST_SUM + 1;
    localparam int NSTG    = ST_OUT + 1;

    localparam int AX_YAW   = 0;
    localparam int AX_PITCH = 1;
    localparam int AX_ROLL  = 2;
    localparam int N_AX     = 3;

    localparam logic [1:0] QD_FIRST  = 2'd0;
    localparam logic [1:0] QD_SECOND = 2'd1;
    localparam logic [1:0] QD_THIRD  = 2'd2;
    localparam logic [1:0] QD_FOURTH = 2'd3;

    logic [NSTG:0]   w_en;
    logic [NSTG-1:0] r_vld, n_vld;

    erb_pkg::t_req   r_req;
    logic [AB-1:0]   w_ang [N_AX];

    erb_pkg::t_side  r_side1 [N_AX];
    erb_pkg::t_side  r_side2 [N_AX];
    logic [T2_W-1:0] r_t2    [N_AX];

    logic [T2_W-1:0]  w_t2    [N_AX][LVL];
    logic [ACC_W-1:0] w_acc_s [N_AX][LVL+1];
    logic [ACC_W-1:0] w_acc_c [N_AX][LVL+1];
    erb_pkg::t_side   w_side  [N_AX][LVL+1];

    logic signed [TRIG_W-1:0] n_sin [N_AX];
    logic signed [TRIG_W-1:0] n_cos [N_AX];
    logic signed [TRIG_W-1:0] r_sin [N_AX];
    logic signed [TRIG_W-1:0] r_cos [N_AX];

    logic signed [TRIG_W-1:0] r_p1_cycr, r_p1_cysr, r_p1_sy, r_p1_spsy, r_p1_cpsy;
    logic signed [TRIG_W-1:0] r_p1_sr, r_p1_cr, r_p1_cpsr, r_p1_cpcr, r_p1_spsr;
    logic signed [TRIG_W-1:0] r_p1_spcr, r_p1_spcy, r_p1_cpcy;

    logic signed [TRIG_W-1:0] r_p2_cycr, r_p2_cysr, r_p2_sy, r_p2_cpsr, r_p2_cpcr;
    logic signed [TRIG_W-1:0] r_p2_spsr, r_p2_spcr, r_p2_spcy, r_p2_cpcy;
    logic signed [TRIG_W-1:0] r_p2_ssc, r_p2_sss, r_p2_csc, r_p2_css;

    logic signed [SUM_W-1:0]  r_sum [9];
    erb_pkg::t_rsp            r_rsp;

    // stage control: advance when empty or when the next stage advances
    assign w_en[NSTG] = i_out_ready;
    for (genvar s = 0; s < NSTG; s++) begin : g_en
        assign w_en[s] = ~r_vld[s] | w_en[s+1];
    end

    assign n_vld = (w_en[NSTG-1:0] & {r_vld[NSTG-2:0], i_in_valid})
                 | (~w_en[NSTG-1:0] & r_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = w_en[ST_IN];
    assign o_out_valid = r_vld[ST_OUT];
    assign o_out_data  = r_rsp;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_IN]) begin
            r_req <= i_in_data;
        end
    end

    assign w_ang[AX_YAW]   = r_req.yaw_angle;
    assign w_ang[AX_PITCH] = r_req.pitch_angle;
    assign w_ang[AX_ROLL]  = r_req.roll_angle;

    for (genvar g = 0; g < N_AX; g++) begin : g_ax
        logic [Q-1:0]     w_f;
        logic [TP_W-1:0]  w_tp;
        logic [T2P_W-1:0] w_t2p;
        logic [SP_W-1:0]  w_sp;
        logic signed [TRIG_W-1:0] w_s, w_c;

        assign w_f  = Q'(w_ang[g][AB-3:0]) << (Q - (AB - 2));
        assign w_tp = TP_W'(w_f) * TP_W'(erb_pkg::HALF_PI_Q) + TP_W'(erb_pkg::HALF_Q);

        always_ff @(posedge i_clk) begin
            if (w_en[ST_T]) begin
                r_side1[g].t    <= T_W'(w_tp >> Q);
                r_side1[g].quad <= w_ang[g][AB-1 -: 2];
            end
        end

        assign w_t2p = T2P_W'(r_side1[g].t) * T2P_W'(r_side1[g].t)
                     + T2P_W'(erb_pkg::HALF_Q);

        always_ff @(posedge i_clk) begin
            if (w_en[ST_T2]) begin
                r_t2[g]    <= T2_W'(w_t2p >> Q);
                r_side2[g] <= r_side1[g];
            end
        end

        assign w_t2[g][0]    = r_t2[g];
        assign w_acc_s[g][0] = erb_pkg::ONE_Q;
        assign w_acc_c[g][0] = erb_pkg::ONE_Q;
        assign w_side[g][0]  = r_side2[g];

        for (genvar k = 0; k < LVL; k++) begin : g_cell
            if (k < LVL - 1) begin : g_mid
                erb_horner_cell #(
                    .LEVEL(LVL - k)
                ) u_cell (
                    .i_clk     (i_clk),
                    .i_en      (w_en[ST_CELL + 2*k +: 2]),
                    .i_t2      (w_t2[g][k]),
                    .i_acc_sin (w_acc_s[g][k]),
                    .i_acc_cos (w_acc_c[g][k]),
                    .i_side    (w_side[g][k]),
                    .o_t2      (w_t2[g][k+1]),
                    .o_acc_sin (w_acc_s[g][k+1]),
                    .o_acc_cos (w_acc_c[g][k+1]),
                    .o_side    (w_side[g][k+1])
                );
            end else begin : g_last
                erb_horner_cell #(
                    .LEVEL(LVL - k)
                ) u_cell (
                    .i_clk     (i_clk),
                    .i_en      (w_en[ST_CELL + 2*k +: 2]),
                    .i_t2      (w_t2[g][k]),
                    .i_acc_sin (w_acc_s[g][k]),
                    .i_acc_cos (w_acc_c[g][k]),
                    .i_side    (w_side[g][k]),
                    .o_t2      (),
                    .o_acc_sin (w_acc_s[g][k+1]),
                    .o_acc_cos (w_acc_c[g][k+1]),
                    .o_side    (w_side[g][k+1])
                );
            end
        end

        assign w_sp = SP_W'(w_side[g][LVL].t) * SP_W'(w_acc_s[g][LVL])
                    + SP_W'(erb_pkg::HALF_Q);
        assign w_s  = $signed({1'b0, T_W'(w_sp >> Q)});
        assign w_c  = $signed({1'b0, w_acc_c[g][LVL]});

        // fold the first-quadrant pair into the full turn
        always_comb begin
            unique case (w_side[g][LVL].quad)
                QD_FIRST: begin
                    n_sin[g] = w_s;
                    n_cos[g] = w_c;
                end
                QD_SECOND: begin
                    n_sin[g] = w_c;
                    n_cos[g] = -w_s;
                end
                QD_THIRD: begin
                    n_sin[g] = -w_s;
                    n_cos[g] = -w_c;
                end
                QD_FOURTH: begin
                    n_sin[g] = -w_c;
                    n_cos[g] = w_s;
                end
            endcase
        end

        always_ff @(posedge i_clk) begin
            if (w_en[ST_SC]) begin
                r_sin[g] <= n_sin[g];
                r_cos[g] <= n_cos[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_P1]) begin
            r_p1_cycr <= erb_pkg::mulq(r_cos[AX_YAW],   r_cos[AX_ROLL]);
            r_p1_cysr <= erb_pkg::mulq(r_cos[AX_YAW],   r_sin[AX_ROLL]);
            r_p1_sy   <= r_sin[AX_YAW];
            r_p1_spsy <= erb_pkg::mulq(r_sin[AX_PITCH], r_sin[AX_YAW]);
            r_p1_cpsy <= erb_pkg::mulq(r_cos[AX_PITCH], r_sin[AX_YAW]);
            r_p1_sr   <= r_sin[AX_ROLL];
            r_p1_cr   <= r_cos[AX_ROLL];
            r_p1_cpsr <= erb_pkg::mulq(r_cos[AX_PITCH], r_sin[AX_ROLL]);
            r_p1_cpcr <= erb_pkg::mulq(r_cos[AX_PITCH], r_cos[AX_ROLL]);
            r_p1_spsr <= erb_pkg::mulq(r_sin[AX_PITCH], r_sin[AX_ROLL]);
            r_p1_spcr <= erb_pkg::mulq(r_sin[AX_PITCH], r_cos[AX_ROLL]);
            r_p1_spcy <= erb_pkg::mulq(r_sin[AX_PITCH], r_cos[AX_YAW]);
            r_p1_cpcy <= erb_pkg::mulq(r_cos[AX_PITCH], r_cos[AX_YAW]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_P2]) begin
            r_p2_cycr <= r_p1_cycr;
            r_p2_cysr <= r_p1_cysr;
            r_p2_sy   <= r_p1_sy;
            r_p2_cpsr <= r_p1_cpsr;
            r_p2_cpcr <= r_p1_cpcr;
            r_p2_spsr <= r_p1_spsr;
            r_p2_spcr <= r_p1_spcr;
            r_p2_spcy <= r_p1_spcy;
            r_p2_cpcy <= r_p1_cpcy;
            r_p2_ssc  <= erb_pkg::mulq(r_p1_spsy, r_p1_cr);
            r_p2_sss  <= erb_pkg::mulq(r_p1_spsy, r_p1_sr);
            r_p2_csc  <= erb_pkg::mulq(r_p1_cpsy, r_p1_cr);
            r_p2_css  <= erb_pkg::mulq(r_p1_cpsy, r_p1_sr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_SUM]) begin
            r_sum[0] <= SUM_W'(r_p2_cycr);
            r_sum[1] <= SUM_W'(r_p2_cysr);
            r_sum[2] <= -SUM_W'(r_p2_sy);
            r_sum[3] <= SUM_W'(r_p2_ssc) - SUM_W'(r_p2_cpsr);
            r_sum[4] <= SUM_W'(r_p2_sss) + SUM_W'(r_p2_cpcr);
            r_sum[5] <= SUM_W'(r_p2_spcy);
            r_sum[6] <= SUM_W'(r_p2_csc) + SUM_W'(r_p2_spsr);
            r_sum[7] <= SUM_W'(r_p2_css) - SUM_W'(r_p2_spcr);
            r_sum[8] <= SUM_W'(r_p2_cpcy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_OUT]) begin
            r_rsp.right_x <= erb_pkg::to_out(r_sum[0]);
            r_rsp.right_y <= erb_pkg::to_out(r_sum[1]);
            r_rsp.right_z <= erb_pkg::to_out(r_sum[2]);
            r_rsp.up_x    <= erb_pkg::to_out(r_sum[3]);
            r_rsp.up_y    <= erb_pkg::to_out(r_sum[4]);
            r_rsp.up_z    <= erb_pkg::to_out(r_sum[5]);
            r_rsp.fwd_x   <= erb_pkg::to_out(r_sum[6]);
            r_rsp.fwd_y   <= erb_pkg::to_out(r_sum[7]);
            r_rsp.fwd_z   <= erb_pkg::to_out(r_sum[8]);
        end
    end

endmodule

// ===== hdl/erb_horner_cell.sv =====
// One Horner level of the sine and cosine series for one angle, two pipeline stages.
module erb_horner_cell #(
    parameter int LEVEL = erb_pkg::HORNER_LEVELS
) (
    input  logic                        i_clk,
    input  logic [1:0]                  i_en,
    input  logic [erb_pkg::T2_W-1:0]    i_t2,
    input  logic [erb_pkg::ACC_W-1:0]   i_acc_sin,
    input  logic [erb_pkg::ACC_W-1:0]   i_acc_cos,
    input  erb_pkg::t_side              i_side,
    output logic [erb_pkg::T2_W-1:0]    o_t2,
    output logic [erb_pkg::ACC_W-1:0]   o_acc_sin,
    output logic [erb_pkg::ACC_W-1:0]   o_acc_cos,
    output erb_pkg::t_side              o_side
);

    localparam int T2_W   = erb_pkg::T2_W;
    localparam int ACC_W  = erb_pkg::ACC_W;
    localparam int D_SIN  = (2 * LEVEL) * (2 * LEVEL + 1);
    localparam int D_COS  = (2 * LEVEL - 1) * (2 * LEVEL);
    localparam int SH_SIN = T2_W + $clog2(D_SIN);
    localparam int SH_COS = T2_W + $clog2(D_COS);
    localparam int M_W    = T2_W + 2;
    localparam int PA_W   = T2_W + ACC_W;
    localparam int PB_W   = T2_W + M_W;
    localparam logic [63:0] M_SIN = ((64'd1 << SH_SIN) + 64'(D_SIN - 1)) / 64'(D_SIN);
    localparam logic [63:0] M_COS = ((64'd1 << SH_COS) + 64'(D_COS - 1)) / 64'(D_COS);

    logic [PA_W-1:0]  w_pa_sin, w_pa_cos;
    logic [PB_W-1:0]  w_pb_sin, w_pb_cos;
    logic [T2_W-1:0]  w_q_sin, w_q_cos;
    logic [ACC_W-1:0] n_acc_sin, n_acc_cos;

    logic [T2_W-1:0]  r_x_sin, r_x_cos, r_t2_a, r_t2_b;
    logic [ACC_W-1:0] r_acc_sin, r_acc_cos;
    erb_pkg::t_side   r_side_a, r_side_b;

    assign w_pa_sin = PA_W'(i_t2) * PA_W'(i_acc_sin);
    assign w_pa_cos = PA_W'(i_t2) * PA_W'(i_acc_cos);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x_sin  <= T2_W'(w_pa_sin >> erb_pkg::Q);
            r_x_cos  <= T2_W'(w_pa_cos >> erb_pkg::Q);
            r_t2_a   <= i_t2;
            r_side_a <= i_side;
        end
    end

    assign w_pb_sin = PB_W'(r_x_sin) * PB_W'(M_SIN[M_W-1:0]);
    assign w_pb_cos = PB_W'(r_x_cos) * PB_W'(M_COS[M_W-1:0]);
    assign w_q_sin  = T2_W'(w_pb_sin >> SH_SIN);
    assign w_q_cos  = T2_W'(w_pb_cos >> SH_COS);

    assign n_acc_sin = (w_q_sin >= T2_W'(erb_pkg::ONE_Q)) ? '0
                     : ACC_W'(T2_W'(erb_pkg::ONE_Q) - w_q_sin);
    assign n_acc_cos = (w_q_cos >= T2_W'(erb_pkg::ONE_Q)) ? '0
                     : ACC_W'(T2_W'(erb_pkg::ONE_Q) - w_q_cos);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_acc_sin <= n_acc_sin;
            r_acc_cos <= n_acc_cos;
            r_t2_b    <= r_t2_a;
            r_side_b  <= r_side_a;
        end
    end

    assign o_t2      = r_t2_b;
    assign o_acc_sin = r_acc_sin;
    assign o_acc_cos = r_acc_cos;
    assign o_side    = r_side_b;

endmodule

// ===== hdl/erb_checker.sv =====
// Port-level checker for the rotation basis block, bound to the top level.
module erb_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input erb_pkg::t_rsp o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_stall_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("request refused while output stage is empty");

    a_right_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_out_data.right_x <= erb_pkg::LIM_Q && o_out_data.right_x >= -erb_pkg::LIM_Q &&
            o_out_data.right_z <= erb_pkg::LIM_Q && o_out_data.right_z >= -erb_pkg::LIM_Q)
        else $error("right vector component beyond one");

    a_fwd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_out_data.fwd_z <= erb_pkg::LIM_Q && o_out_data.fwd_z >= -erb_pkg::LIM_Q &&
            o_out_data.up_z <= erb_pkg::LIM_Q && o_out_data.up_z >= -erb_pkg::LIM_Q)
        else $error("forward or up component beyond one");

endmodule

bind euler_to_rotation_basis erb_checker u_erb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
